FILE: sv/sphere_overlap_insert_check_top_macros.svh
// Assertion helpers for the sphere overlap insert check block.
`ifndef SPHERE_OVERLAP_INSERT_CHECK_TOP_MACROS_SVH
`define SPHERE_OVERLAP_INSERT_CHECK_TOP_MACROS_SVH

// Same-cycle implication.
`define SOOC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SOOC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/sooc_pkg.sv
package sooc_pkg;

   localparam int MAX_SPHERES_DEFAULT = 256;
   localparam int COORD_W             = 20;
   localparam int RAD_W               = 16;
   localparam int DIFF_W              = COORD_W + 1;
   localparam int SQ_W                = 2 * DIFF_W;
   localparam int DSQ_W               = SQ_W + 2;
   localparam int RSUM_W              = RAD_W + 1;
   localparam int RSQ_W               = 2 * RSUM_W;
   localparam int STATUS_W            = 2;
   localparam int HELD_W              = 9;
   localparam int PIPE_DEPTH          = 3;

   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERLAP  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   typedef struct packed {
      logic                      func;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic        [RAD_W-1:0]   radius;
   } sooc_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HELD_W-1:0]   entries_held;
   } sooc_rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic        [RAD_W-1:0]   r;
   } sooc_entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } sooc_cell_ctl_type;

endpackage

FILE: sv/sooc_cell.sv
module sooc_cell (
   input  logic                        clock,
   input  sooc_pkg::sooc_cell_ctl_type ctl,
   input  sooc_pkg::sooc_entry_type    next_data,
   input  sooc_pkg::sooc_entry_type    load_data,
   output sooc_pkg::sooc_entry_type    data
);
   import sooc_pkg::*;

   sooc_entry_type entry_ff;
   sooc_entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = load_data;
      end else if (ctl.shift) begin
         entry_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data = entry_ff;

endmodule

FILE: sv/sooc_cmp.sv
module sooc_cmp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid,
   input  sooc_pkg::sooc_entry_type cand,
   input  sooc_pkg::sooc_entry_type stored,
   output logic                     hit
);
   import sooc_pkg::*;

   logic                     v1_ff, v2_ff, hit_ff;
   logic                     v1_in, v2_in, hit_in;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [DIFF_W-1:0] dx_in, dy_in, dz_in;
   logic        [RSUM_W-1:0] rs_ff, rs_in;
   logic signed [SQ_W-1:0]   sqx_ff, sqy_ff, sqz_ff;
   logic signed [SQ_W-1:0]   sqx_in, sqy_in, sqz_in;
   logic        [RSQ_W-1:0]  rsq_ff, rsq_in;
   logic        [DSQ_W-1:0]  dsq;

   // stage 1: differences and radius sum
   always_comb begin
      v1_in = valid;
      dx_in = DIFF_W'(cand.x) - DIFF_W'(stored.x);
      dy_in = DIFF_W'(cand.y) - DIFF_W'(stored.y);
      dz_in = DIFF_W'(cand.z) - DIFF_W'(stored.z);
      rs_in = RSUM_W'(cand.r) + RSUM_W'(stored.r);
   end

   // stage 2: squares
   always_comb begin
      v2_in  = v1_ff;
      sqx_in = SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_in = SQ_W'(dy_ff) * SQ_W'(dy_ff);
      sqz_in = SQ_W'(dz_ff) * SQ_W'(dz_ff);
      rsq_in = RSQ_W'(rs_ff) * RSQ_W'(rs_ff);
   end

   // stage 3: distance sum and compare, touching counts as overlap
   always_comb begin
      dsq    = DSQ_W'($unsigned(sqx_ff)) + DSQ_W'($unsigned(sqy_ff))
             + DSQ_W'($unsigned(sqz_ff));
      hit_in = v2_ff && (dsq <= DSQ_W'(rsq_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      dz_ff  <= dz_in;
      rs_ff  <= rs_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      sqz_ff <= sqz_in;
      rsq_ff <= rsq_in;
   end

   assign hit = hit_ff;

endmodule

FILE: sv/sphere_overlap_insert_check_top.sv
// Sphere overlap insert check. The placed spheres sit in a ring of MAX_SPHERES
// cells that rotates by one cell per cycle past a single three-stage compare
// unit; a test item therefore goes through accept, one full turn of the ring,
// pipeline drain and result, whatever the fill, and a clear goes straight from
// accept to result. One item is in work at a time; a new request transfer is
// taken once the previous result has been loaded into the output register,
// even while that result still waits to be taken. A new sphere is written
// into the cell at the fill count if its test finds no overlap and a cell is free.
`include "sphere_overlap_insert_check_top_macros.svh"

module sphere_overlap_insert_check_top #(
   parameter int MAX_SPHERES = sooc_pkg::MAX_SPHERES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sooc_pkg::sooc_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sooc_pkg::sooc_rsp_type rsp_data
);
   import sooc_pkg::*;

   localparam int CNT_W     = $clog2(MAX_SPHERES + 1);
   localparam int STEP_W    = $clog2(MAX_SPHERES + PIPE_DEPTH + 1);
   localparam int STEP_LAST = MAX_SPHERES + PIPE_DEPTH - 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              hit_ff, hit_in;
   logic              clear_ff, clear_in;
   sooc_entry_type    cand_ff, cand_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sooc_rsp_type      rsp_data_ff, rsp_data_in;

   logic              req_take;
   logic              out_free;
   logic              shift;
   logic              append;
   logic              scan_valid;
   logic              cmp_hit;
   logic [31:0]       held32;
   sooc_entry_type    ring [MAX_SPHERES];

   assign req_take   = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign shift      = (state_ff == S_SCAN) && (32'(step_ff) < MAX_SPHERES);
   assign scan_valid = (state_ff == S_SCAN) && (32'(step_ff) < 32'(count_ff));
   assign append     = (state_ff == S_FINISH) && out_free && !clear_ff && !hit_ff
                       && (32'(count_ff) < MAX_SPHERES);

   genvar gi;
   generate
      for (gi = 0; gi < MAX_SPHERES; gi++) begin : g_cell
         sooc_cell_ctl_type ctl;
         assign ctl.shift = shift;
         assign ctl.load  = append && (count_ff == CNT_W'(gi));
         sooc_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .next_data (ring[(gi + 1) % MAX_SPHERES]),
            .load_data (cand_ff),
            .data      (ring[gi])
         );
      end
   endgenerate

   sooc_cmp u_cmp (
      .clock  (clock),
      .reset  (reset),
      .valid  (scan_valid),
      .cand   (cand_ff),
      .stored (ring[0]),
      .hit    (cmp_hit)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      hit_in       = hit_ff | cmp_hit;
      clear_in     = clear_ff;
      cand_in      = cand_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      held32       = 32'(count_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cand_in.x = req_data.pos_x;
               cand_in.y = req_data.pos_y;
               cand_in.z = req_data.pos_z;
               cand_in.r = req_data.radius;
               clear_in  = (req_data.func == FUNC_CLEAR);
               hit_in    = 1'b0;
               step_in   = '0;
               state_in  = (req_data.func == FUNC_CLEAR) ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEP_LAST)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               if (clear_ff) begin
                  count_in           = '0;
                  rsp_data_in.status = ST_CLEARED;
               end else if (hit_ff) begin
                  rsp_data_in.status = ST_OVERLAP;
               end else if (append) begin
                  count_in           = count_ff + 1'b1;
                  rsp_data_in.status = ST_ACCEPTED;
               end else begin
                  rsp_data_in.status = ST_FULL;
               end
               held32                   = 32'(count_in);
               rsp_data_in.entries_held = held32[HELD_W-1:0];
               rsp_valid_in             = 1'b1;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         clear_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SOOC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= MAX_SPHERES, "fill count above capacity")
   `SOOC_ASSERT_NEXT(a_take_busy, clock, reset, req_take, state_ff != S_IDLE, "accepted item left block idle")
   `SOOC_ASSERT_NOW(a_clear_empty, clock, reset, rsp_valid && rsp_data.status == ST_CLEARED, rsp_data.entries_held == '0, "clear left entries")
   `SOOC_ASSERT_NEXT(a_append_grows, clock, reset, append, 32'(count_ff) == 32'($past(count_ff)) + 1, "append did not grow count")

endmodule
